@@ sv/nlc_pkg.sv @@
// ----------------------------------------------------------------------------
// nlc_pkg
// Character codes and scan state type for the numeric literal checker.
// ----------------------------------------------------------------------------
package nlc_pkg;

    localparam int unsigned UnitWidth = 16;
    localparam int unsigned OutBytes  = 1;

    localparam logic [UnitWidth-1:0] ChMinus = 16'h002D;
    localparam logic [UnitWidth-1:0] ChPlus  = 16'h002B;
    localparam logic [UnitWidth-1:0] ChPoint = 16'h002E;
    localparam logic [UnitWidth-1:0] ChZero  = 16'h0030;
    localparam logic [UnitWidth-1:0] ChNine  = 16'h0039;
    localparam logic [UnitWidth-1:0] ChLowE  = 16'h0065;
    localparam logic [UnitWidth-1:0] ChUpE   = 16'h0045;
    localparam logic [UnitWidth-1:0] ChLowX  = 16'h0078;
    localparam logic [UnitWidth-1:0] ChUpX   = 16'h0058;
    localparam logic [UnitWidth-1:0] ChLowA  = 16'h0061;
    localparam logic [UnitWidth-1:0] ChLowD  = 16'h0064;
    localparam logic [UnitWidth-1:0] ChLowF  = 16'h0066;
    localparam logic [UnitWidth-1:0] ChUpA   = 16'h0041;
    localparam logic [UnitWidth-1:0] ChUpD   = 16'h0044;
    localparam logic [UnitWidth-1:0] ChUpF   = 16'h0046;

    // unit position codes, saturating at POS_LATE
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_LATE   = 2'd3;

    typedef struct packed {
        logic       sign_seen;
        logic       digit_seen;
        logic       point_seen;
        logic       exponent_seen;
        logic       hex_mode;
        logic       rejected;
        logic [1:0] unit_position;
        logic       lead_was_sign;
        logic       prior_was_zero;
    } t_scan_state;

    localparam t_scan_state ScanClear = '0;

endpackage

@@ sv/numeric_literal_checker.sv @@
// ----------------------------------------------------------------------------
// numeric_literal_checker
// Streams a string in one 16-bit code unit per request and reports, on the
// last unit, whether the whole string is a numeric literal.
// ----------------------------------------------------------------------------
// Input channel s_axis: tdata carries the code unit, tuser marks the first
// unit of a string, tlast marks the final unit. A tuser unit clears the scan
// state before it is taken; after a tlast unit the state is cleared as well.
// Output channel m_axis: one request per string, tdata[0] = is_number.
// Units without tlast produce no output request.
// Throughput: one unit per cycle while s_axis_tready is high; the scan flags
// update through short compare logic from the state registers to the result register.
// Output timing: the result is registered and appears on m_axis in the cycle
// after the tlast unit is accepted.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
// is high whenever the result register is empty or being drained, so input
// only waits while a result is pending and the receiver is stalled.
// Reset (i_rst_n low, synchronous): scan state cleared, no result pending.
// ----------------------------------------------------------------------------
module numeric_literal_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [nlc_pkg::UnitWidth-1:0] s_axis_tdata,  // [15:0] code_unit
    input  logic                        s_axis_tuser,  // [0] first_unit
    input  logic                        s_axis_tlast,  // last_unit
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [8*nlc_pkg::OutBytes-1:0] m_axis_tdata  // [0] is_number, rest zero
);
    import nlc_pkg::*;

    t_scan_state r_state, n_state;
    t_scan_state base, upd;
    logic        r_out_valid, n_out_valid;
    logic        r_out_num, n_out_num;
    logic        accept;
    logic        is_sign;
    logic        is_digit;
    logic        is_exp;
    logic        is_hex_letter;
    logic        is_x;
    logic [UnitWidth-1:0] c;

    assign c      = s_axis_tdata;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    always_comb begin
        is_sign       = (c == ChMinus) || (c == ChPlus);
        is_digit      = (c inside {[ChZero:ChNine]});
        is_exp        = (c == ChLowE) || (c == ChUpE);
        is_hex_letter = (c inside {[ChLowA:ChLowD], ChLowF, [ChUpA:ChUpD], ChUpF});
        is_x          = (c == ChLowX) || (c == ChUpX);
    end

    always_comb begin
        base = s_axis_tuser ? ScanClear : r_state;
        upd  = base;
        if (!base.rejected) begin
            if (is_sign) begin
                if (base.digit_seen || base.point_seen || base.sign_seen || base.hex_mode)
                    upd.rejected = 1'b1;
                else
                    upd.sign_seen = 1'b1;
            end else if (c == ChPoint) begin
                if (base.point_seen || base.exponent_seen || base.hex_mode)
                    upd.rejected = 1'b1;
                else
                    upd.point_seen = 1'b1;
            end else if (is_digit) begin
                upd.digit_seen = 1'b1;
            end else if (is_exp) begin
                // exponent marker is ignored once in hex mode
                if (!base.hex_mode) begin
                    if (!base.digit_seen || base.exponent_seen) begin
                        upd.rejected = 1'b1;
                    end else begin
                        upd.exponent_seen = 1'b1;
                        upd.digit_seen    = 1'b0;
                        upd.point_seen    = 1'b0;
                        upd.sign_seen     = 1'b0;
                    end
                end
            end else if (is_hex_letter) begin
                if (!base.hex_mode)
                    upd.rejected = 1'b1;
                else
                    upd.digit_seen = 1'b1;
            end else if (is_x) begin
                // prefix only as "0x" at the start, or after a leading sign
                if (!base.hex_mode && base.prior_was_zero &&
                    ((base.unit_position == POS_SECOND) ||
                     (base.unit_position == POS_THIRD && base.lead_was_sign)))
                    upd.hex_mode = 1'b1;
                else
                    upd.rejected = 1'b1;
            end else begin
                upd.rejected = 1'b1;
            end
        end
        if (base.unit_position == POS_FIRST)
            upd.lead_was_sign = is_sign;
        upd.prior_was_zero = (c == ChZero);
        if (base.unit_position != POS_LATE)
            upd.unit_position = base.unit_position + 2'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_num   = r_out_num;
        if (accept) begin
            if (s_axis_tlast) begin
                n_state     = ScanClear;
                n_out_valid = 1'b1;
                n_out_num   = !upd.rejected && upd.digit_seen;
            end else begin
                n_state = upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ScanClear;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_num <= n_out_num;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8*OutBytes-1){1'b0}}, r_out_num};

endmodule

@@ sv/nlc_checker.sv @@
// ----------------------------------------------------------------------------
// nlc_checker
// Port-level checks for the numeric literal checker, bound to the top level.
// ----------------------------------------------------------------------------
module nlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // a fresh result comes only from an accepted last unit
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && !m_axis_tready) ##1 m_axis_tvalid |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result without a last unit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with no result pending");

endmodule

bind numeric_literal_checker nlc_checker u_nlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
